// ===== hdl/fpt_pkg.sv =====
// shared types, register indexes and sine table for the floor projection block
package fpt_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HEADING = 3'd0,
        CFG_CAM_X   = 3'd1,
        CFG_CAM_Y   = 3'd2,
        CFG_ZOOM    = 3'd3,
        CFG_FOCAL   = 3'd4,
        CFG_SCR_W   = 3'd5,
        CFG_SCR_H   = 3'd6,
        CFG_UNUSED  = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [9:0] screen_col;
        logic [9:0] screen_row;
    } t_pix_in;

    typedef struct packed {
        logic [7:0] tex_u;
        logic [7:0] tex_v;
        logic [8:0] fade;
        logic       on_floor;
    } t_tex_out;

    // what rides along the divider next to the quotients
    typedef struct packed {
        logic        neg_u;
        logic        frac_u;
        logic        neg_v;
        logic        frac_v;
        logic [23:0] k_u;
        logic [23:0] k_v;
        logic        on_floor;
    } t_side;

    // q14 sine, first quadrant
    function automatic logic [14:0] quarter_sine(input logic [6:0] d);
        logic [14:0] v;
        unique case (d)
            7'd0: v = 15'd0;        7'd1: v = 15'd286;      7'd2: v = 15'd572;
            7'd3: v = 15'd857;      7'd4: v = 15'd1143;     7'd5: v = 15'd1428;
            7'd6: v = 15'd1713;     7'd7: v = 15'd1997;     7'd8: v = 15'd2280;
            7'd9: v = 15'd2563;     7'd10: v = 15'd2845;    7'd11: v = 15'd3126;
            7'd12: v = 15'd3406;    7'd13: v = 15'd3686;    7'd14: v = 15'd3964;
            7'd15: v = 15'd4240;    7'd16: v = 15'd4516;    7'd17: v = 15'd4790;
            7'd18: v = 15'd5063;    7'd19: v = 15'd5334;    7'd20: v = 15'd5604;
            7'd21: v = 15'd5871;    7'd22: v = 15'd6138;    7'd23: v = 15'd6402;
            7'd24: v = 15'd6664;    7'd25: v = 15'd6924;    7'd26: v = 15'd7182;
            7'd27: v = 15'd7438;    7'd28: v = 15'd7692;    7'd29: v = 15'd7943;
            7'd30: v = 15'd8192;    7'd31: v = 15'd8438;    7'd32: v = 15'd8682;
            7'd33: v = 15'd8923;    7'd34: v = 15'd9162;    7'd35: v = 15'd9397;
            7'd36: v = 15'd9630;    7'd37: v = 15'd9860;    7'd38: v = 15'd10087;
            7'd39: v = 15'd10311;   7'd40: v = 15'd10531;   7'd41: v = 15'd10749;
            7'd42: v = 15'd10963;   7'd43: v = 15'd11174;   7'd44: v = 15'd11381;
            7'd45: v = 15'd11585;   7'd46: v = 15'd11786;   7'd47: v = 15'd11982;
            7'd48: v = 15'd12176;   7'd49: v = 15'd12365;   7'd50: v = 15'd12551;
            7'd51: v = 15'd12733;   7'd52: v = 15'd12911;   7'd53: v = 15'd13085;
            7'd54: v = 15'd13255;   7'd55: v = 15'd13421;   7'd56: v = 15'd13583;
            7'd57: v = 15'd13741;   7'd58: v = 15'd13894;   7'd59: v = 15'd14044;
            7'd60: v = 15'd14189;   7'd61: v = 15'd14330;   7'd62: v = 15'd14466;
            7'd63: v = 15'd14598;   7'd64: v = 15'd14726;   7'd65: v = 15'd14849;
            7'd66: v = 15'd14968;   7'd67: v = 15'd15082;   7'd68: v = 15'd15191;
            7'd69: v = 15'd15296;   7'd70: v = 15'd15396;   7'd71: v = 15'd15491;
            7'd72: v = 15'd15582;   7'd73: v = 15'd15668;   7'd74: v = 15'd15749;
            7'd75: v = 15'd15826;   7'd76: v = 15'd15897;   7'd77: v = 15'd15964;
            7'd78: v = 15'd16026;   7'd79: v = 15'd16083;   7'd80: v = 15'd16135;
            7'd81: v = 15'd16182;   7'd82: v = 15'd16225;   7'd83: v = 15'd16262;
            7'd84: v = 15'd16294;   7'd85: v = 15'd16322;   7'd86: v = 15'd16344;
            7'd87: v = 15'd16362;   7'd88: v = 15'd16374;   7'd89: v = 15'd16382;
            7'd90: v = 15'd16384;
            default: v = 15'd0;
        endcase
        return v;
    endfunction

    // q14 sine of an angle already reduced below 360
    function automatic logic signed [15:0] sine_q14(input logic [8:0] d);
        logic [14:0] m;
        logic        neg;
        if (d <= 9'd90) begin
            m = quarter_sine(d[6:0]);
            neg = 1'b0;
        end else if (d <= 9'd180) begin
            m = quarter_sine(7'(9'd180 - d));
            neg = 1'b0;
        end else if (d <= 9'd270) begin
            m = quarter_sine(7'(d - 9'd180));
            neg = 1'b1;
        end else begin
            m = quarter_sine(7'(9'd360 - d));
            neg = 1'b1;
        end
        return neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
    endfunction

endpackage

// ===== hdl/fpt_div_pipe.sv =====
// pipelined restoring divider, one quotient bit per stage, several lanes in step
module fpt_div_pipe
    import fpt_pkg::*;
#(
    parameter int LANES = 3,
    parameter int NUM_W = 30,
    parameter int DEN_W = 22,
    parameter int SB_W  = 1
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_vld,
    input  logic [LANES-1:0][NUM_W-1:0]       i_num,
    input  logic [LANES-1:0][DEN_W-1:0]       i_den,
    input  logic [SB_W-1:0]                   i_sb,
    output logic                              o_vld,
    output logic [LANES-1:0][NUM_W-1:0]       o_quo,
    output logic [LANES-1:0]                  o_rem_nz,
    output logic [SB_W-1:0]                   o_sb
);

    logic [NUM_W:0]                            w_vld;
    logic [NUM_W:0][LANES-1:0][NUM_W-1:0]      w_nq;
    logic [NUM_W:0][LANES-1:0][DEN_W-1:0]      w_rem;
    logic [NUM_W:0][LANES-1:0][DEN_W-1:0]      w_den;
    logic [NUM_W:0][SB_W-1:0]                  w_sb;

    assign w_vld[0] = i_vld;
    assign w_nq[0]  = i_num;
    assign w_rem[0] = '0;
    assign w_den[0] = i_den;
    assign w_sb[0]  = i_sb;

    for (genvar s = 0; s < NUM_W; s++) begin : g_stage
        logic [LANES-1:0][NUM_W-1:0] n_nq;
        logic [LANES-1:0][DEN_W-1:0] n_rem;
        logic [LANES-1:0][NUM_W-1:0] r_nq;
        logic [LANES-1:0][DEN_W-1:0] r_rem;
        logic [LANES-1:0][DEN_W-1:0] r_den;
        logic [SB_W-1:0]             r_sb;
        logic                        r_vld;

        always_comb begin
            logic [DEN_W:0] trial;
            for (int l = 0; l < LANES; l++) begin
                trial = {w_rem[s][l], w_nq[s][l][NUM_W-1]};
                if (trial >= {1'b0, w_den[s][l]}) begin
                    n_rem[l] = DEN_W'(trial - {1'b0, w_den[s][l]});
                    n_nq[l]  = {w_nq[s][l][NUM_W-2:0], 1'b1};
                end else begin
                    n_rem[l] = trial[DEN_W-1:0];
                    n_nq[l]  = {w_nq[s][l][NUM_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else begin
                r_vld <= w_vld[s];
            end
            r_nq  <= n_nq;
            r_rem <= n_rem;
            r_den <= w_den[s];
            r_sb  <= w_sb[s];
        end

        assign w_vld[s+1] = r_vld;
        assign w_nq[s+1]  = r_nq;
        assign w_rem[s+1] = r_rem;
        assign w_den[s+1] = r_den;
        assign w_sb[s+1]  = r_sb;
    end

    assign o_vld = w_vld[NUM_W];
    assign o_quo = w_nq[NUM_W];
    assign o_sb  = w_sb[NUM_W];

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            o_rem_nz[l] = |w_rem[NUM_W][l];
        end
    end

endmodule

// ===== hdl/floor_perspective_texcoord.sv =====
// top level: rotated perspective floor projection to wrapped texture coordinates
//
// one pixel beat (column, row) in, one result beat out, a new pixel may be
// started in every cycle and busy never rises. every result is strobed by
// o_valid for one cycle, in start order; the receiver must take it then.
// each result passes through five front stages for the angle lookup,
// rotation products, zoom scaling and sign handling, the 30-stage restoring
// divider (one quotient bit per stage) and one output register. configuration
// writes take effect at once and belong between frames, when no pixel is in
// flight.
module floor_perspective_texcoord
    import fpt_pkg::*;
#(
    parameter int TEX_W_LOG2 = 8,
    parameter int TEX_H_LOG2 = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  t_pix_in               i_pix,
    output logic                  o_valid,
    output t_tex_out              o_res,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int NUM_W = 30;
    localparam int DEN_W = 22;
    localparam int SB_W  = $bits(t_side);

    // low bits kept after wrapping to the texture size, then to 8 bits
    localparam logic [7:0] U_MASK = 8'((64'd1 << TEX_W_LOG2) - 64'd1);
    localparam logic [7:0] V_MASK = 8'((64'd1 << TEX_H_LOG2) - 64'd1);

    // configuration registers
    logic [8:0]  r_heading;
    logic [15:0] r_cam_x;
    logic [15:0] r_cam_y;
    logic [7:0]  r_zoom;
    logic [9:0]  r_focal;
    logic [10:0] r_scr_w;
    logic [10:0] r_scr_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heading <= 9'd0;
            r_cam_x   <= 16'd0;
            r_cam_y   <= 16'd0;
            r_zoom    <= 8'd1;
            r_focal   <= 10'd128;
            r_scr_w   <= 11'd640;
            r_scr_h   <= 11'd480;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_HEADING: r_heading <= i_cfg_data[8:0];
                CFG_CAM_X:   r_cam_x   <= i_cfg_data;
                CFG_CAM_Y:   r_cam_y   <= i_cfg_data;
                CFG_ZOOM:    r_zoom    <= i_cfg_data[7:0];
                CFG_FOCAL:   r_focal   <= i_cfg_data[9:0];
                CFG_SCR_W:   r_scr_w   <= i_cfg_data[10:0];
                CFG_SCR_H:   r_scr_h   <= i_cfg_data[10:0];
                default: ;
            endcase
        end
    end

    // fully pipelined, no back pressure anywhere
    assign busy = 1'b0;

    // stage 1: center offsets, horizon test, sine and cosine lookup
    logic [9:0]  hw;
    logic [9:0]  hh;
    logic [8:0]  ang;
    logic [9:0]  ang_c_raw;
    logic [8:0]  ang_c;
    logic        n1_floor;

    assign hw = r_scr_w[10:1];
    assign hh = r_scr_h[10:1];
    assign ang = (r_heading >= 9'd360) ? 9'(r_heading - 9'd360) : r_heading;
    assign ang_c_raw = {1'b0, ang} + 10'd90;
    assign ang_c = (ang_c_raw >= 10'd360) ? 9'(ang_c_raw - 10'd360) : ang_c_raw[8:0];
    assign n1_floor = (i_pix.screen_row >= hh);

    logic               r1_vld;
    logic signed [11:0] r1_x;
    logic [10:0]        r1_y;
    logic [9:0]         r1_zd;
    logic               r1_floor;
    logic signed [15:0] r1_s;
    logic signed [15:0] r1_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else begin
            r1_vld <= start;
        end
        r1_x     <= $signed({2'b00, hw}) - $signed({2'b00, i_pix.screen_col});
        r1_y     <= {1'b0, i_pix.screen_row} + {1'b0, r_focal};
        r1_zd    <= 10'(i_pix.screen_row - hh);
        r1_floor <= n1_floor;
        r1_s     <= sine_q14(ang);
        r1_c     <= sine_q14(ang_c);
    end

    // stage 2: rotation products, depth term, scaled camera offsets
    logic               r2_vld;
    logic signed [27:0] r2_xc;
    logic signed [27:0] r2_ys;
    logic signed [27:0] r2_yc;
    logic signed [27:0] r2_xs;
    logic [19:0]        r2_zq;
    logic [17:0]        r2_zk;
    logic [21:0]        r2_dfade;
    logic [23:0]        r2_ku;
    logic [23:0]        r2_kv;
    logic               r2_floor;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else begin
            r2_vld <= r1_vld;
        end
        r2_xc    <= 28'(r1_x) * 28'(r1_c);
        r2_ys    <= 28'($signed({1'b0, r1_y})) * 28'(r1_s);
        r2_yc    <= 28'($signed({1'b0, r1_y})) * 28'(r1_c);
        r2_xs    <= 28'(r1_x) * 28'(r1_s);
        // zq = depth in 1/1000 units, the +1 is the 0.001 bias
        r2_zq    <= 20'({10'd0, r1_zd} * 20'd1000 + 20'd1);
        r2_zk    <= 18'({10'd0, r_zoom} * 18'd1000);
        r2_dfade <= 22'({12'd0, hh} * 22'd3000);
        r2_ku    <= 24'({8'd0, r_cam_y} * {16'd0, r_zoom});
        r2_kv    <= 24'({8'd0, r_cam_x} * {16'd0, r_zoom});
        r2_floor <= r1_floor;
    end

    // stage 3: rotated q14 coordinates
    logic               r3_vld;
    logic signed [28:0] r3_rx;
    logic signed [28:0] r3_ry;
    logic [19:0]        r3_zq;
    logic [17:0]        r3_zk;
    logic [21:0]        r3_dfade;
    logic [23:0]        r3_ku;
    logic [23:0]        r3_kv;
    logic               r3_floor;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else begin
            r3_vld <= r2_vld;
        end
        r3_rx    <= 29'(r2_xc) - 29'(r2_ys);
        r3_ry    <= 29'(r2_yc) + 29'(r2_xs);
        r3_zq    <= r2_zq;
        r3_zk    <= r2_zk;
        r3_dfade <= r2_dfade;
        r3_ku    <= r2_ku;
        r3_kv    <= r2_kv;
        r3_floor <= r2_floor;
    end

    // stage 4: numerators rx * zoom * 1000, fade numerator zq * 256
    logic               r4_vld;
    logic signed [47:0] r4_au;
    logic signed [47:0] r4_av;
    logic [27:0]        r4_fnum;
    logic [19:0]        r4_zq;
    logic [21:0]        r4_dfade;
    logic [23:0]        r4_ku;
    logic [23:0]        r4_kv;
    logic               r4_floor;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else begin
            r4_vld <= r3_vld;
        end
        r4_au    <= 48'(r3_rx) * 48'($signed({1'b0, r3_zk}));
        r4_av    <= 48'(r3_ry) * 48'($signed({1'b0, r3_zk}));
        r4_fnum  <= {r3_zq, 8'd0};
        r4_zq    <= r3_zq;
        r4_dfade <= r3_dfade;
        r4_ku    <= r3_ku;
        r4_kv    <= r3_kv;
        r4_floor <= r3_floor;
    end

    // stage 5: drop the q14 fraction (floor), split into sign and magnitude
    logic signed [33:0] nu;
    logic signed [33:0] nv;
    logic [33:0]        nu_abs;
    logic [33:0]        nv_abs;

    assign nu = r4_au[47:14];
    assign nv = r4_av[47:14];
    assign nu_abs = nu[33] ? 34'(-nu) : 34'(nu);
    assign nv_abs = nv[33] ? 34'(-nv) : 34'(nv);

    logic                         r5_vld;
    logic [2:0][NUM_W-1:0]        r5_num;
    logic [2:0][DEN_W-1:0]        r5_den;
    t_side                        r5_sb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
        end else begin
            r5_vld <= r4_vld;
        end
        r5_num[0]      <= nu_abs[NUM_W-1:0];
        r5_num[1]      <= nv_abs[NUM_W-1:0];
        r5_num[2]      <= {2'b00, r4_fnum};
        r5_den[0]      <= {2'b00, r4_zq};
        r5_den[1]      <= {2'b00, r4_zq};
        r5_den[2]      <= r4_dfade;
        r5_sb.neg_u    <= nu[33];
        r5_sb.frac_u   <= |r4_au[13:0];
        r5_sb.neg_v    <= nv[33];
        r5_sb.frac_v   <= |r4_av[13:0];
        r5_sb.k_u      <= r4_ku;
        r5_sb.k_v      <= r4_kv;
        r5_sb.on_floor <= r4_floor;
    end

    // lanes: u, v, fade
    logic                  dv_vld;
    logic [2:0][NUM_W-1:0] dv_quo;
    logic [2:0]            dv_rem_nz;
    logic [SB_W-1:0]       dv_sb_bits;
    t_side                 dv_sb;

    fpt_div_pipe #(
        .LANES (3),
        .NUM_W (NUM_W),
        .DEN_W (DEN_W),
        .SB_W  (SB_W)
    ) u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_vld    (r5_vld),
        .i_num    (r5_num),
        .i_den    (r5_den),
        .i_sb     (r5_sb),
        .o_vld    (dv_vld),
        .o_quo    (dv_quo),
        .o_rem_nz (dv_rem_nz),
        .o_sb     (dv_sb_bits)
    );

    assign dv_sb = t_side'(dv_sb_bits);

    // floor quotient, subtract the camera term, then round toward zero
    logic signed [31:0] qf_u;
    logic signed [31:0] qf_v;
    logic signed [33:0] t_u;
    logic signed [33:0] t_v;
    logic signed [33:0] q_u;
    logic signed [33:0] q_v;
    logic               nz_u;
    logic               nz_v;
    logic [8:0]         fade;
    t_tex_out           n_res;

    assign qf_u = dv_sb.neg_u ? -$signed({2'b00, dv_quo[0]}) - 32'(dv_rem_nz[0])
                              : $signed({2'b00, dv_quo[0]});
    assign qf_v = dv_sb.neg_v ? -$signed({2'b00, dv_quo[1]}) - 32'(dv_rem_nz[1])
                              : $signed({2'b00, dv_quo[1]});
    assign nz_u = dv_sb.frac_u | dv_rem_nz[0];
    assign nz_v = dv_sb.frac_v | dv_rem_nz[1];
    assign t_u  = 34'(qf_u) - $signed({10'd0, dv_sb.k_u});
    assign t_v  = 34'(qf_v) - $signed({10'd0, dv_sb.k_v});
    assign q_u  = t_u + 34'(nz_u && t_u[33]);
    assign q_v  = t_v + 34'(nz_v && t_v[33]);
    // a zero divisor (no horizon) gives an all-ones quotient, which saturates too
    assign fade = (dv_quo[2] > NUM_W'(256)) ? 9'd256 : dv_quo[2][8:0];

    always_comb begin
        if (dv_sb.on_floor) begin
            n_res.tex_u    = q_u[7:0] & U_MASK;
            n_res.tex_v    = q_v[7:0] & V_MASK;
            n_res.fade     = fade;
            n_res.on_floor = 1'b1;
        end else begin
            n_res = '0;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= dv_vld;
        end
        o_res <= n_res;
    end

endmodule

// ===== sim/floor_perspective_texcoord_tb.sv =====
`timescale 1ns / 1ps
// self-checking bench for the floor projection block: directed pixels, then fixed and random frames
module floor_perspective_texcoord_tb;
    import fpt_pkg::*;

    localparam int  LIMIT_CYCLES = 300000;
    localparam int  TAIL_CYCLES  = 60;
    localparam int  N_PHASES     = 8;
    localparam int  RAND_PER_PHASE = 210;

    // q14 first-quadrant sine, whole degrees
    localparam int QSIN [0:90] = '{
        0, 286, 572, 857, 1143, 1428, 1713, 1997, 2280, 2563,
        2845, 3126, 3406, 3686, 3964, 4240, 4516, 4790, 5063, 5334,
        5604, 5871, 6138, 6402, 6664, 6924, 7182, 7438, 7692, 7943,
        8192, 8438, 8682, 8923, 9162, 9397, 9630, 9860, 10087, 10311,
        10531, 10749, 10963, 11174, 11381, 11585, 11786, 11982, 12176, 12365,
        12551, 12733, 12911, 13085, 13255, 13421, 13583, 13741, 13894, 14044,
        14189, 14330, 14466, 14598, 14726, 14849, 14968, 15082, 15191, 15296,
        15396, 15491, 15582, 15668, 15749, 15826, 15897, 15964, 16026, 16083,
        16135, 16182, 16225, 16262, 16294, 16322, 16344, 16362, 16374, 16382,
        16384};

    typedef struct {
        logic [9:0] col;
        logic [9:0] row;
        bit         known;     // expected result typed in below
        t_tex_out   res;
    } t_pix_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    t_pix_in               i_pix = '0;
    logic                  o_valid;
    t_tex_out              o_res;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    // side band riding with start: directed rows with a typed-in answer
    bit       typed_known = 1'b0;
    t_tex_out typed_res = '0;

    // shadow of the block's settings
    logic [8:0]  heading_sh;
    logic [15:0] cam_x_sh, cam_y_sh;
    logic [7:0]  zoom_sh;
    logic [9:0]  focal_sh;
    logic [10:0] scr_w_sh, scr_h_sh;

    t_tex_out texel_q[$];
    bit       failed = 1'b0;
    int       idle_pct = 0;
    int       cycle_cnt = 0;

    floor_perspective_texcoord dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_pix      (i_pix),
        .o_valid    (o_valid),
        .o_res      (o_res),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // q14 sine with the angle taken mod 360
    function automatic longint heading_sine(input int unsigned deg);
        int unsigned d;
        d = deg % 360;
        if (d <= 90) return QSIN[d];
        if (d <= 180) return QSIN[180 - d];
        if (d <= 270) return -QSIN[d - 180];
        return -QSIN[360 - d];
    endfunction

    // perspective divide, saturate to 32 bits, keep the low 8 bits
    function automatic logic [7:0] wrap_coord(input longint r, input longint cam,
                                              input longint zq);
        longint den, num, q;
        den = zq * 16384;
        num = (r * 1000 - cam * den) * longint'(zoom_sh);
        q = num / den;
        if (q > 64'sd2147483647) q = 64'sd2147483647;
        if (q < -64'sd2147483648) q = -64'sd2147483648;
        return q[7:0];
    endfunction

    function automatic t_tex_out floor_texel(input t_pix_in p);
        t_tex_out t;
        longint   hw, hh, col, row, s, c, x, y, zq, fd;
        t = '0;
        col = p.screen_col;
        row = p.screen_row;
        hw = scr_w_sh >> 1;
        hh = scr_h_sh >> 1;
        if (row < hh) return t;
        s = heading_sine(heading_sh);
        c = heading_sine(heading_sh + 90);
        x = hw - col;
        y = row + focal_sh;
        zq = (row - hh) * 1000 + 1;
        if (hh == 0) fd = 256;
        else begin
            fd = (zq * 256) / (3000 * hh);
            if (fd > 256) fd = 256;
        end
        t.tex_u = wrap_coord(x * c - y * s, cam_y_sh, zq);
        t.tex_v = wrap_coord(y * c + x * s, cam_x_sh, zq);
        t.fade = fd[8:0];
        t.on_floor = 1'b1;
        return t;
    endfunction

    // settings shadow, expectations on accepted beats, checks on result beats
    always @(posedge i_clk) begin
        t_tex_out e;
        if (!i_rst_n) begin
            heading_sh <= '0;
            cam_x_sh <= '0;
            cam_y_sh <= '0;
            zoom_sh <= 8'd1;
            focal_sh <= 10'd128;
            scr_w_sh <= 11'd640;
            scr_h_sh <= 11'd480;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_HEADING: heading_sh <= i_cfg_data[8:0];
                    CFG_CAM_X:   cam_x_sh <= i_cfg_data;
                    CFG_CAM_Y:   cam_y_sh <= i_cfg_data;
                    CFG_ZOOM:    zoom_sh <= i_cfg_data[7:0];
                    CFG_FOCAL:   focal_sh <= i_cfg_data[9:0];
                    CFG_SCR_W:   scr_w_sh <= i_cfg_data[10:0];
                    CFG_SCR_H:   scr_h_sh <= i_cfg_data[10:0];
                    default: ;
                endcase
            end
            if (start && !busy)
                texel_q.push_back(typed_known ? typed_res : floor_texel(i_pix));
            if (o_valid) begin
                if (texel_q.size() == 0) begin
                    $error("result beat with nothing expected");
                    failed = 1'b1;
                end else begin
                    e = texel_q.pop_front();
                    if (o_res.tex_u !== e.tex_u) begin
                        $error("tex_u expected %0d got %0d", e.tex_u, o_res.tex_u);
                        failed = 1'b1;
                    end
                    if (o_res.tex_v !== e.tex_v) begin
                        $error("tex_v expected %0d got %0d", e.tex_v, o_res.tex_v);
                        failed = 1'b1;
                    end
                    if (o_res.fade !== e.fade) begin
                        $error("fade expected %0d got %0d", e.fade, o_res.fade);
                        failed = 1'b1;
                    end
                    if (o_res.on_floor !== e.on_floor) begin
                        $error("on_floor expected %0d got %0d", e.on_floor,
                               o_res.on_floor);
                        failed = 1'b1;
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > LIMIT_CYCLES) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // one pixel beat, with random sender gaps ahead of it
    task automatic send_pixel(input logic [9:0] col, input logic [9:0] row,
                              input bit known, input t_tex_out res);
        bit took;
        while ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start <= 1'b1;
        i_pix <= '{screen_col: col, screen_row: row};
        typed_known <= known;
        typed_res <= res;
        do begin
            took = !busy;
            @(negedge i_clk);
        end while (!took);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [15:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
    endtask

    // settings change only with the pipe drained
    task automatic drain;
        start <= 1'b0;
        @(negedge i_clk);
        while (texel_q.size() != 0) @(negedge i_clk);
    endtask

    task automatic set_frame(input logic [15:0] hd, input logic [15:0] cx,
                             input logic [15:0] cy, input logic [15:0] zm,
                             input logic [15:0] fo, input logic [15:0] sw,
                             input logic [15:0] sh);
        drain();
        write_reg(CFG_HEADING, hd);
        write_reg(CFG_CAM_X, cx);
        write_reg(CFG_CAM_Y, cy);
        write_reg(CFG_ZOOM, zm);
        write_reg(CFG_FOCAL, fo);
        write_reg(CFG_SCR_W, sw);
        write_reg(CFG_SCR_H, sh);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    initial begin
        t_pix_row     dir_rows[$];
        t_tex_out     zero_res;
        t_tex_out     none;
        int           hh;
        logic [9:0]   c, r;
        zero_res = '0;
        none = '0;

        // reset frame: 640x480, horizon at row 240
        dir_rows = '{
            '{10'd0,    10'd0,    1'b1, zero_res},   // top corner, sky
            '{10'd1023, 10'd239,  1'b1, zero_res},   // last sky row
            '{10'd320,  10'd240,  1'b0, none},       // horizon row: saturation
            '{10'd0,    10'd240,  1'b0, none},
            '{10'd1023, 10'd240,  1'b0, none},
            '{10'd320,  10'd241,  1'b0, none},
            '{10'd639,  10'd479,  1'b0, none},
            '{10'd1023, 10'd1023, 1'b0, none},       // off screen
            '{10'd0,    10'd1023, 1'b0, none},
            '{10'd512,  10'd960,  1'b0, none},       // fade reaches full
            '{10'd341,  10'd341,  1'b0, none},
            '{10'd682,  10'd682,  1'b0, none}
        };

        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_rows[k])
            send_pixel(dir_rows[k].col, dir_rows[k].row, dir_rows[k].known,
                       dir_rows[k].res);

        // heading past 359, zero zoom, zero horizon: every row is floor
        set_frame(16'd450, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd1);
        send_pixel(10'd0, 10'd0, 1'b0, none);
        send_pixel(10'd1023, 10'd1023, 1'b0, none);
        send_pixel(10'd5, 10'd700, 1'b0, none);

        for (int ph = 0; ph < N_PHASES; ph++) begin
            case (ph)
                0: set_frame(16'd0, 16'd0, 16'd0, 16'd1, 16'd128, 16'd640, 16'd480);
                1: set_frame(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                             16'hFFFF, 16'hFFFF);              // all bits high
                2: set_frame(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
                3: set_frame(16'd359, 16'd65535, 16'd0, 16'd255, 16'd1023,
                             16'd2, 16'd2);
                default: set_frame(16'($urandom), 16'($urandom), 16'($urandom),
                                   16'($urandom), 16'($urandom), 16'($urandom),
                                   16'($urandom));
            endcase
            // no gaps, sparse sender, moderate sender
            case (ph % 4)
                0: idle_pct = 0;
                1: idle_pct = 88;
                2: idle_pct = 29;
                default: idle_pct = 0;
            endcase
            hh = scr_h_sh >> 1;
            if (hh > 1023) hh = 1023;
            for (int n = 0; n < RAND_PER_PHASE; n++) begin
                c = 10'($urandom);
                case ($urandom_range(0, 9))
                    0, 1: r = 10'($urandom);
                    2:    r = 10'(hh);                          // horizon
                    default: r = 10'($urandom_range(hh, 1023)); // floor
                endcase
                send_pixel(c, r, 1'b0, none);
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (!failed && texel_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== floor_perspective_texcoord.f =====
hdl/fpt_pkg.sv
hdl/fpt_div_pipe.sv
hdl/floor_perspective_texcoord.sv
sim/floor_perspective_texcoord_tb.sv
